[design/ppfci_pkg.sv]
`default_nettype none
package ppfci_pkg;
    localparam int IDX_W   = 31;
    localparam int CELLS_W = 12;
    localparam int ROW_W   = CELLS_W + 1;
    localparam int PLANE_W = 2 * ROW_W - 1;
    localparam int SIZE_W  = 31;
    localparam int OFF_W   = 16;
    localparam int POS_W   = 32;
    localparam int TERM_FRAC = 15;
    localparam int OFF_FRAC  = 14;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_X     = 3'd0,
        REG_CELLS_Y     = 3'd1,
        REG_CELL_SIZE_X = 3'd2,
        REG_CELL_SIZE_Y = 3'd3,
        REG_CELL_SIZE_Z = 3'd4
    } cfg_reg_t;
endpackage
`default_nettype wire

[design/ppfci_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per stage.
module ppfci_div import ppfci_pkg::*; #(
    parameter int NW = 31,
    parameter int DW = 25,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          valid_i,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] div_i,
    input  wire logic [SW-1:0] side_i,
    output logic               valid_o,
    output logic [NW-1:0]      quo_o,
    output logic [DW-1:0]      rem_o,
    output logic [SW-1:0]      side_o
);
    logic          vld_reg  [1:NW];
    logic [DW-1:0] rem_reg  [1:NW];
    logic [NW-1:0] num_reg  [1:NW];
    logic [NW-1:0] quo_reg  [1:NW];
    logic [SW-1:0] side_reg [1:NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_s;
        logic [DW-1:0] r_s;
        logic [NW-1:0] n_s;
        logic [NW-1:0] q_s;
        logic [SW-1:0] s_s;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        if (i == 0) begin : g_first
            assign v_s = valid_i;
            assign r_s = '0;
            assign n_s = num_i;
            assign q_s = '0;
            assign s_s = side_i;
        end else begin : g_rest
            assign v_s = vld_reg[i];
            assign r_s = rem_reg[i];
            assign n_s = num_reg[i];
            assign q_s = quo_reg[i];
            assign s_s = side_reg[i];
        end

        assign trial = {r_s, n_s[NW-1]};
        assign ge    = trial >= {1'b0, div_i};
        assign diff  = trial - {1'b0, div_i};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= v_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                num_reg[i+1]  <= {n_s[NW-2:0], 1'b0};
                quo_reg[i+1]  <= {q_s[NW-2:0], ge};
                side_reg[i+1] <= s_s;
            end
        end
    end

    assign valid_o = vld_reg[NW];
    assign quo_o   = quo_reg[NW];
    assign rem_o   = rem_reg[NW];
    assign side_o  = side_reg[NW];
endmodule
`default_nettype wire

[design/ppfci_axis.sv]
`default_nettype none
// origin + floor(((i-1) + (off+1)/2) * size), saturated; four stages.
module ppfci_axis import ppfci_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [IDX_W-1:0]        coord,
    input  wire logic signed [OFF_W-1:0] off,
    input  wire logic [SIZE_W-1:0]       size,
    input  wire logic signed [POS_W-1:0] org,
    output logic signed [POS_W-1:0]      pos
);
    localparam int TERM_W = IDX_W + TERM_FRAC + 2;
    localparam int MAG_W  = TERM_W - 1;
    localparam int HI_W   = MAG_W - TERM_FRAC;
    localparam int PH_W   = HI_W + SIZE_W;
    localparam int PL_W   = TERM_FRAC + SIZE_W;
    localparam int PROD_W = 64;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [TERM_W-1:0] term;
    logic [MAG_W-1:0]         mag_next;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_a_reg;
    logic signed [POS_W-1:0]  org_a_reg;
    logic [PH_W-1:0]          ph_reg;
    logic [PL_W-1:0]          pl_reg;
    logic                     neg_b_reg;
    logic signed [POS_W-1:0]  org_b_reg;
    logic [PL_W-1:0]          part;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_c_reg;
    logic signed [POS_W-1:0]  org_c_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [POS_W-1:0]  pos_next;
    logic signed [POS_W-1:0]  pos_reg;

    assign term = ((TERM_W'(coord) - TERM_W'(1)) <<< TERM_FRAC)
                + TERM_W'(off) + (TERM_W'(1) <<< OFF_FRAC);
    assign mag_next = term[TERM_W-1] ? MAG_W'(-term) : MAG_W'(term);

    assign part = pl_reg + (neg_b_reg ? PL_W'((1 << TERM_FRAC) - 1) : PL_W'(0));
    assign prod_next = PROD_W'(ph_reg) + PROD_W'(part >> TERM_FRAC);

    assign sum = neg_c_reg ? (SUM_W'(org_c_reg) - $signed({2'b00, prod_reg}))
                           : (SUM_W'(org_c_reg) + $signed({2'b00, prod_reg}));

    always_comb
    begin
        if (sum > SUM_W'(32'sh7FFF_FFFF))
            pos_next = 32'sh7FFF_FFFF;
        else if (sum < -(SUM_W'(64'sh8000_0000)))
            pos_next = 32'sh8000_0000;
        else
            pos_next = sum[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            neg_a_reg <= term[TERM_W-1];
            org_a_reg <= org;
            ph_reg    <= PH_W'(mag_reg[MAG_W-1:TERM_FRAC]) * PH_W'(size);
            pl_reg    <= PL_W'(mag_reg[TERM_FRAC-1:0]) * PL_W'(size);
            neg_b_reg <= neg_a_reg;
            org_b_reg <= org_a_reg;
            prod_reg  <= prod_next;
            neg_c_reg <= neg_b_reg;
            org_c_reg <= org_b_reg;
            pos_reg   <= pos_next;
        end
    end

    assign pos = pos_reg;
endmodule
`default_nettype wire

[design/particle_position_from_cell_index.sv]
// A transfer passes the plane divider, then the row divider, then the axis pipelines.
// Throughput: one transfer per cycle while no result waits under out_stall; set by the bit-per-stage divider chains.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, asynchronous) clears all valid bits and the registers to
// cells 1, cell size 1.0.
`default_nettype none
module particle_position_from_cell_index import ppfci_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [SIZE_W-1:0]       cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [IDX_W-1:0]        cell_index,
    input  wire logic signed [OFF_W-1:0] offset_x,
    input  wire logic signed [OFF_W-1:0] offset_y,
    input  wire logic signed [OFF_W-1:0] offset_z,
    input  wire logic signed [POS_W-1:0] origin_x,
    input  wire logic signed [POS_W-1:0] origin_y,
    input  wire logic signed [POS_W-1:0] origin_z,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [POS_W-1:0]      pos_x,
    output logic signed [POS_W-1:0]      pos_y,
    output logic signed [POS_W-1:0]      pos_z
);
    localparam int SIDE1_W = 3 * OFF_W + 3 * POS_W;
    localparam int SIDE2_W = SIDE1_W + IDX_W;
    localparam int AX_LAT  = 4;

    logic [CELLS_W-1:0] cells_x_reg;
    logic [CELLS_W-1:0] cells_y_reg;
    logic [SIZE_W-1:0]  size_x_reg;
    logic [SIZE_W-1:0]  size_y_reg;
    logic [SIZE_W-1:0]  size_z_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic               adv;

    logic               v1;
    logic [IDX_W-1:0]   q1;
    logic [PLANE_W-1:0] r1;
    logic [SIDE1_W-1:0] s1;
    logic               v2;
    logic [PLANE_W-1:0] q2;
    logic [ROW_W-1:0]   r2;
    logic [SIDE2_W-1:0] s2;
    logic [AX_LAT-1:0]  vax_reg;

    logic signed [OFF_W-1:0] ox, oy, oz;
    logic signed [POS_W-1:0] gx, gy, gz;
    logic [IDX_W-1:0]        iz;

    // row and plane sizes follow the cell counts at the write edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CELLS_W'(1);
            cells_y_reg <= CELLS_W'(1);
            size_x_reg  <= SIZE_W'(65536);
            size_y_reg  <= SIZE_W'(65536);
            size_z_reg  <= SIZE_W'(65536);
            row_reg     <= ROW_W'(3);
            plane_reg   <= PLANE_W'(9);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELLS_X:
                begin
                    cells_x_reg <= cfg_data[CELLS_W-1:0];
                    row_reg     <= ROW_W'(cfg_data[CELLS_W-1:0]) + ROW_W'(2);
                    plane_reg   <= PLANE_W'(ROW_W'(cfg_data[CELLS_W-1:0]) + ROW_W'(2))
                                 * PLANE_W'(ROW_W'(cells_y_reg) + ROW_W'(2));
                end
                REG_CELLS_Y:
                begin
                    cells_y_reg <= cfg_data[CELLS_W-1:0];
                    plane_reg   <= PLANE_W'(ROW_W'(cells_x_reg) + ROW_W'(2))
                                 * PLANE_W'(ROW_W'(cfg_data[CELLS_W-1:0]) + ROW_W'(2));
                end
                REG_CELL_SIZE_X: size_x_reg  <= cfg_data;
                REG_CELL_SIZE_Y: size_y_reg  <= cfg_data;
                REG_CELL_SIZE_Z: size_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    ppfci_div #(.NW(IDX_W), .DW(PLANE_W), .SW(SIDE1_W)) u_div_plane (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (in_valid),
        .num_i   (cell_index),
        .div_i   (plane_reg),
        .side_i  ({offset_x, offset_y, offset_z, origin_x, origin_y, origin_z}),
        .valid_o (v1),
        .quo_o   (q1),
        .rem_o   (r1),
        .side_o  (s1)
    );

    ppfci_div #(.NW(PLANE_W), .DW(ROW_W), .SW(SIDE2_W)) u_div_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (v1),
        .num_i   (r1),
        .div_i   (row_reg),
        .side_i  ({q1, s1}),
        .valid_o (v2),
        .quo_o   (q2),
        .rem_o   (r2),
        .side_o  (s2)
    );

    assign {iz, ox, oy, oz, gx, gy, gz} = s2;

    ppfci_axis u_axis_x (
        .clk (clk), .en (adv), .coord (IDX_W'(r2)), .off (ox),
        .size (size_x_reg), .org (gx), .pos (pos_x)
    );
    ppfci_axis u_axis_y (
        .clk (clk), .en (adv), .coord (IDX_W'(q2)), .off (oy),
        .size (size_y_reg), .org (gy), .pos (pos_y)
    );
    ppfci_axis u_axis_z (
        .clk (clk), .en (adv), .coord (iz), .off (oz),
        .size (size_z_reg), .org (gz), .pos (pos_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vax_reg <= '0;
        end
        else if (adv)
        begin
            vax_reg <= {vax_reg[AX_LAT-2:0], v2};
        end
    end

    assign out_valid = vax_reg[AX_LAT-1];

`ifndef SYNTHESIS
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input held without a waiting result");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vax_reg))
        else $error("pipeline moved while held");
    a_free_run: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input held with empty output");
`endif
endmodule
`default_nettype wire
